@@ rtl/gwwb_pkg.sv @@
// Shared types and constants of the greedy word-wrap line breaker.
package gwwb_pkg;

  localparam int          ACC_W     = 24;
  localparam int          OUT_POS_W = 16;
  localparam int          CNT_W     = 16;
  localparam int          METRIC_W  = 48;

  localparam logic [7:0]       CHAR_NL   = 8'd10;
  localparam logic [7:0]       CHAR_SP   = 8'd32;
  localparam logic [ACC_W-1:0] WIDTH_MAX = 24'hFF_FFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Glyph metrics of one character, as kept in the word buffer.
  typedef struct packed {
    logic               has_glyph;
    logic signed [15:0] x_offset;
    logic [14:0]        glyph_width;
    logic signed [15:0] advance;
  } metric_t;

  // One classified character on its way from the front to the back.
  typedef struct packed {
    logic    is_nl;
    logic    is_space;
    logic    is_alnum;
    logic    is_last;
    metric_t m;
  } item_t;

endpackage

@@ rtl/gwwb_if.sv @@
// Channel interfaces of the line breaker: characters in, line breaks out, width limit.
interface gwwb_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         char_code;
  logic               has_glyph;
  logic signed [15:0] advance;
  logic [14:0]        glyph_width;
  logic signed [15:0] x_offset;
  logic               is_last;

  modport source (output valid, char_code, has_glyph, advance, glyph_width, x_offset,
                  is_last, input ready);
  modport sink   (input valid, char_code, has_glyph, advance, glyph_width, x_offset,
                  is_last, output ready);
endinterface

interface gwwb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_line_start;
  logic [15:0] line_number;
  logic        text_done;
  logic        run_last;

  modport source (output valid, next_line_start, line_number, text_done, run_last,
                  input ready);
  modport sink   (input valid, next_line_start, line_number, text_done, run_last,
                  output ready);
endinterface

interface gwwb_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] line_limit;

  modport source (output valid, line_limit, input ready);
  modport sink   (input valid, line_limit, output ready);
endinterface

@@ rtl/gwwb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gwwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/gwwb_front.sv @@
// Front end: accepts characters, classifies them and queues them for the back end.
module gwwb_front (
  input  logic              clk,
  input  logic              rst_n,
  gwwb_in_if.sink           in_ch,
  output gwwb_pkg::item_t   head,
  output logic              head_valid,
  input  logic              pop
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  gwwb_pkg::item_t   q_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  gwwb_pkg::item_t   item;
  logic              push;

  // Classify the character while it is accepted.
  always_comb begin
    item.is_nl         = (in_ch.char_code == gwwb_pkg::CHAR_NL);
    item.is_space      = (in_ch.char_code == gwwb_pkg::CHAR_SP);
    item.is_alnum      = in_ch.char_code inside {[8'h41:8'h5A], [8'h61:8'h7A],
                                                 [8'h30:8'h39]};
    item.is_last       = in_ch.is_last;
    item.m.has_glyph   = in_ch.has_glyph;
    item.m.x_offset    = in_ch.x_offset;
    item.m.glyph_width = in_ch.glyph_width;
    item.m.advance     = in_ch.advance;
  end

  assign in_ch.ready = (fill_r != FILL_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = q_r[rd_ptr_r];
  assign head_valid  = (fill_r != '0);

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

@@ rtl/gwwb_back.sv @@
// Back end: line-width tracking, word buffering, word replay and result ordering.
module gwwb_back #(
  parameter int MAX_WORD = 32,
  parameter int POS_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gwwb_pkg::item_t              q_item,
  input  logic                         q_valid,
  output logic                         q_pop,
  gwwb_cfg_if.sink                     cfg_ch,
  gwwb_out_if.source                   out_ch,
  output logic                         ram_we,
  output logic [$clog2(MAX_WORD)-1:0]  ram_waddr,
  output logic [gwwb_pkg::METRIC_W-1:0] ram_wdata,
  output logic                         ram_re,
  output logic [$clog2(MAX_WORD)-1:0]  ram_raddr,
  input  logic [gwwb_pkg::METRIC_W-1:0] ram_rdata
);

  localparam int IDX_W = $clog2(MAX_WORD);
  localparam int LEN_W = $clog2(MAX_WORD + 2);
  localparam int ACC_W = gwwb_pkg::ACC_W;
  localparam int CNT_W = gwwb_pkg::CNT_W;
  localparam int OPW   = gwwb_pkg::OUT_POS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RCHK, S_RTAKE, S_TAKE, S_LAST, S_FLUSH
  } state_t;

  state_t              state_r, state_nxt;
  gwwb_pkg::item_t     cur_r, cur_nxt;
  logic [ACC_W-1:0]    max_w_r, max_w_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [POS_BITS-1:0] char_pos_r, char_pos_nxt;
  logic [CNT_W-1:0]    line_cnt_r, line_cnt_nxt;
  logic [POS_BITS-1:0] line_begin_r, line_begin_nxt;
  logic [POS_BITS-1:0] word_begin_r, word_begin_nxt;
  logic                word_open_r, word_open_nxt;
  logic                line_empty_r, line_empty_nxt;
  logic [LEN_W-1:0]    word_len_r, word_len_nxt;
  logic                rp_done_r, rp_done_nxt;
  logic [LEN_W-1:0]    rp_len_r, rp_len_nxt;
  logic [LEN_W-1:0]    rp_idx_r, rp_idx_nxt;
  logic [POS_BITS-1:0] rp_pos_r, rp_pos_nxt;
  logic                h_valid_r, h_valid_nxt;
  logic [OPW-1:0]      h_start_r, h_start_nxt;
  logic [CNT_W-1:0]    h_line_r, h_line_nxt;
  logic                h_done_r, h_done_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OPW-1:0]      out_start_r, out_start_nxt;
  logic [CNT_W-1:0]    out_line_r, out_line_nxt;
  logic                out_done_r, out_done_nxt;
  logic                out_last_r, out_last_nxt;

  // Source selection and datapath.
  logic                replay_src;
  gwwb_pkg::metric_t   sel_m;
  logic                sel_space;
  logic [POS_BITS-1:0] sel_pos;
  logic [14:0]         ext_w;
  logic [ACC_W:0]      ovf_sum;
  logic                ovf;
  logic signed [16:0]  lead_off;
  logic signed [26:0]  wd;
  logic [ACC_W-1:0]    wd_clamped;
  logic [POS_BITS-1:0] p_inc;
  logic [CNT_W-1:0]    cnt_inc;
  logic                out_free;
  logic                emit_ok;
  logic                replay_ok;
  logic [LEN_W-1:0]    idx_inc;

  // Actions decided by the sequencer.
  logic                do_emit, emit_done, do_take, do_flush, do_reset_text, start_next;
  logic [POS_BITS-1:0] emit_start;
  logic [LEN_W-1:0]    len0;

  assign replay_src = (state_r == S_RCHK) || (state_r == S_RTAKE);
  assign sel_m      = replay_src ? gwwb_pkg::metric_t'(ram_rdata) : cur_r.m;
  assign sel_space  = replay_src ? 1'b0 : cur_r.is_space;
  assign sel_pos    = replay_src ? rp_pos_r : char_pos_r;

  // Extent is the larger of advance and bitmap width; never negative.
  assign ext_w   = (sel_m.advance > $signed({1'b0, sel_m.glyph_width})) ?
                   sel_m.advance[14:0] : sel_m.glyph_width;
  assign ovf_sum = {1'b0, acc_r} + (ACC_W+1)'(ext_w);
  assign ovf     = !line_empty_r && sel_m.has_glyph && (ovf_sum > {1'b0, max_w_r});

  // A line's first inked character is pulled right by a negative left offset.
  assign lead_off = (line_empty_r && !sel_space && sel_m.has_glyph && sel_m.x_offset[15]) ?
                    -$signed({sel_m.x_offset[15], sel_m.x_offset}) : 17'sd0;
  assign wd       = $signed({3'b000, acc_r}) + 27'(lead_off) +
                    (sel_m.has_glyph ? 27'(sel_m.advance) : 27'sd0);

  always_comb begin
    if (wd < 27'sd0) begin
      wd_clamped = '0;
    end else if (wd > $signed({3'b000, gwwb_pkg::WIDTH_MAX})) begin
      wd_clamped = gwwb_pkg::WIDTH_MAX;
    end else begin
      wd_clamped = wd[ACC_W-1:0];
    end
  end

  assign p_inc    = char_pos_r + POS_BITS'(1);
  assign cnt_inc  = (line_cnt_r == gwwb_pkg::COUNT_MAX) ? line_cnt_r : line_cnt_r + 1'b1;
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit_ok  = !h_valid_r || out_free;
  assign idx_inc  = rp_idx_r + 1'b1;
  assign replay_ok = !rp_done_r && word_open_r && (word_begin_r != line_begin_r) &&
                     cur_r.is_alnum && (word_len_r < LEN_W'(MAX_WORD));

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    max_w_nxt      = max_w_r;
    acc_nxt        = acc_r;
    char_pos_nxt   = char_pos_r;
    line_cnt_nxt   = line_cnt_r;
    line_begin_nxt = line_begin_r;
    word_begin_nxt = word_begin_r;
    word_open_nxt  = word_open_r;
    line_empty_nxt = line_empty_r;
    word_len_nxt   = word_len_r;
    rp_done_nxt    = rp_done_r;
    rp_len_nxt     = rp_len_r;
    rp_idx_nxt     = rp_idx_r;
    rp_pos_nxt     = rp_pos_r;
    h_valid_nxt    = h_valid_r;
    h_start_nxt    = h_start_r;
    h_line_nxt     = h_line_r;
    h_done_nxt     = h_done_r;
    out_valid_nxt  = out_valid_r;
    out_start_nxt  = out_start_r;
    out_line_nxt   = out_line_r;
    out_done_nxt   = out_done_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = sel_m;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    do_emit        = 1'b0;
    emit_done      = 1'b0;
    emit_start     = char_pos_r;
    do_take        = 1'b0;
    do_flush       = 1'b0;
    do_reset_text  = 1'b0;
    start_next     = 1'b0;
    len0           = word_len_r;

    if (cfg_ch.valid) begin
      max_w_nxt = cfg_ch.line_limit;
    end

    case (state_r)
      S_IDLE: begin
        start_next = 1'b1;
      end
      S_CHECK: begin
        if (cur_r.is_nl) begin
          if (emit_ok) begin
            do_emit    = 1'b1;
            emit_start = p_inc;
            emit_done  = cur_r.is_last;
            if (cur_r.is_last) begin
              do_reset_text = 1'b1;
            end else begin
              char_pos_nxt = p_inc;
            end
            state_nxt = S_FLUSH;
          end
        end else if (ovf) begin
          if (emit_ok) begin
            do_emit = 1'b1;
            if (replay_ok) begin
              emit_start  = word_begin_r;
              rp_done_nxt = 1'b1;
              rp_len_nxt  = word_len_r;
              rp_idx_nxt  = '0;
              rp_pos_nxt  = word_begin_r;
              if (word_len_r != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = S_RCHK;
              end else begin
                state_nxt = S_TAKE;
              end
            end else begin
              emit_start = char_pos_r;
              state_nxt  = S_TAKE;
            end
          end
        end else begin
          state_nxt = S_TAKE;
        end
      end
      S_RCHK: begin
        if (ovf) begin
          if (emit_ok) begin
            do_emit    = 1'b1;
            emit_start = rp_pos_r;
            state_nxt  = S_RTAKE;
          end
        end else begin
          state_nxt = S_RTAKE;
        end
      end
      S_RTAKE: begin
        do_take    = 1'b1;
        rp_idx_nxt = idx_inc;
        rp_pos_nxt = rp_pos_r + POS_BITS'(1);
        if (idx_inc == rp_len_r) begin
          state_nxt = S_CHECK;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[IDX_W-1:0];
          state_nxt = S_RCHK;
        end
      end
      S_TAKE: begin
        do_take = 1'b1;
        if (cur_r.is_last) begin
          state_nxt = S_LAST;
        end else begin
          char_pos_nxt = p_inc;
          if (h_valid_r) begin
            state_nxt = S_FLUSH;
          end else begin
            start_next = 1'b1;
          end
        end
      end
      S_LAST: begin
        if (emit_ok) begin
          do_emit       = 1'b1;
          emit_start    = p_inc;
          emit_done     = 1'b1;
          do_reset_text = 1'b1;
          state_nxt     = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!h_valid_r) begin
          start_next = 1'b1;
        end else if (out_free) begin
          do_flush   = 1'b1;
          start_next = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Add one character to the current line and the current word.
    if (do_take) begin
      line_empty_nxt = 1'b0;
      acc_nxt        = wd_clamped;
      if (sel_space) begin
        word_open_nxt = 1'b0;
        word_len_nxt  = '0;
      end else begin
        if (!word_open_r) begin
          word_open_nxt  = 1'b1;
          word_begin_nxt = sel_pos;
          len0           = '0;
        end
        if (len0 < LEN_W'(MAX_WORD)) begin
          ram_we       = 1'b1;
          ram_waddr    = len0[IDX_W-1:0];
          word_len_nxt = len0 + 1'b1;
        end else begin
          word_len_nxt = LEN_W'(MAX_WORD + 1);
        end
      end
    end

    // Close the current line; the previous held result moves to the output.
    if (do_emit) begin
      h_valid_nxt    = 1'b1;
      h_start_nxt    = OPW'(emit_start);
      h_line_nxt     = cnt_inc;
      h_done_nxt     = emit_done;
      line_cnt_nxt   = cnt_inc;
      line_begin_nxt = emit_start;
      word_begin_nxt = emit_start;
      word_open_nxt  = 1'b1;
      line_empty_nxt = 1'b1;
      acc_nxt        = '0;
      word_len_nxt   = '0;
    end

    if (do_reset_text) begin
      char_pos_nxt   = '0;
      line_cnt_nxt   = '0;
      line_begin_nxt = '0;
      word_begin_nxt = '0;
    end

    if (do_flush) begin
      h_valid_nxt = 1'b0;
    end

    if ((do_emit && h_valid_r) || do_flush) begin
      out_valid_nxt = 1'b1;
      out_start_nxt = h_start_r;
      out_line_nxt  = h_line_r;
      out_done_nxt  = h_done_r;
      out_last_nxt  = do_flush;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (start_next) begin
      if (q_valid) begin
        q_pop       = 1'b1;
        cur_nxt     = q_item;
        rp_done_nxt = 1'b0;
        state_nxt   = S_CHECK;
      end else begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_w_r      <= gwwb_pkg::WIDTH_MAX;
      acc_r        <= '0;
      char_pos_r   <= '0;
      line_cnt_r   <= '0;
      line_begin_r <= '0;
      word_begin_r <= '0;
      word_open_r  <= 1'b1;
      line_empty_r <= 1'b1;
      word_len_r   <= '0;
      rp_done_r    <= 1'b0;
      h_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      max_w_r      <= max_w_nxt;
      acc_r        <= acc_nxt;
      char_pos_r   <= char_pos_nxt;
      line_cnt_r   <= line_cnt_nxt;
      line_begin_r <= line_begin_nxt;
      word_begin_r <= word_begin_nxt;
      word_open_r  <= word_open_nxt;
      line_empty_r <= line_empty_nxt;
      word_len_r   <= word_len_nxt;
      rp_done_r    <= rp_done_nxt;
      h_valid_r    <= h_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cur_r       <= cur_nxt;
    rp_len_r    <= rp_len_nxt;
    rp_idx_r    <= rp_idx_nxt;
    rp_pos_r    <= rp_pos_nxt;
    h_start_r   <= h_start_nxt;
    h_line_r    <= h_line_nxt;
    h_done_r    <= h_done_nxt;
    out_start_r <= out_start_nxt;
    out_line_r  <= out_line_nxt;
    out_done_r  <= out_done_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.next_line_start = out_start_r;
  assign out_ch.line_number     = out_line_r;
  assign out_ch.text_done       = out_done_r;
  assign out_ch.run_last        = out_last_r;

endmodule

@@ rtl/greedy_word_wrap_breaker.sv @@
// Greedy word-wrap line breaker, top level.
//
// The block takes one character word at a time with its glyph metrics (Q4.12 em) and
// returns a result word for every line it closes: the index where the next line starts,
// the saturating line count, whether the text is done, and whether this is the last
// result caused by the character. Lines close on a newline, at the end of the text
// (is_last), or when a glyph would run past the configured line limit. A letter or digit
// that overflows inside a word that did not begin the line moves the whole word to the
// next line; the word's buffered metrics (up to MAX_WORD characters, kept in a RAM) are
// then replayed through the width logic (check, then take, per buffered character), and a
// replayed character that still overflows breaks in place. Longer words break in place.
// A front end classifies characters into a two-entry queue, so input is taken while the
// back end works. A plain character takes a width check, then a width update; each
// character that produces results then passes a flush state to release its final result,
// a newline goes from the check straight to the flush, the last character of a text adds
// a closing state before the flush, and a word move adds a check and a take per replayed
// character, then checks the overflowing character again. An output register lets the
// back end keep going while a finished result waits. Results may stall the back end only
// when two results are pending. There is no clearing pass after reset. The line limit
// resets to the widest line and should be written only while the block is idle.
module greedy_word_wrap_breaker #(
  parameter int MAX_WORD = 32,
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  gwwb_in_if.sink     in_ch,
  gwwb_out_if.source  out_ch,
  gwwb_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = $clog2(MAX_WORD);

  gwwb_pkg::item_t               q_item;
  logic                          q_valid;
  logic                          q_pop;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [gwwb_pkg::METRIC_W-1:0] ram_wdata;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [gwwb_pkg::METRIC_W-1:0] ram_rdata;

  // Accepts characters and queues them already classified.
  gwwb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head       (q_item),
    .head_valid (q_valid),
    .pop        (q_pop)
  );

  // Metrics of the word being built, one entry per character.
  gwwb_ram #(
    .WIDTH (gwwb_pkg::METRIC_W),
    .DEPTH (MAX_WORD)
  ) u_word_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Width tracking, word moves and result ordering.
  gwwb_back #(
    .MAX_WORD (MAX_WORD),
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

@@ rtl/gwwb_checker.sv @@
// Port-level checks of the line breaker and their binding to the top level.
module gwwb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_next_line_start,
  input logic [15:0] out_line_number,
  input logic        out_text_done,
  input logic        out_run_last
);

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_line_start) &&
    $stable(out_line_number) && $stable(out_text_done) && $stable(out_run_last))
    else $error("result word changed while stalled");

  // Closing the text is always the final result of its character.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done |-> out_run_last)
    else $error("text_done without run_last");

  // Every result closes at least one line.
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number != 16'd0)
    else $error("result with line number zero");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind greedy_word_wrap_breaker gwwb_checker u_gwwb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_next_line_start (out_ch.next_line_start),
  .out_line_number     (out_ch.line_number),
  .out_text_done       (out_ch.text_done),
  .out_run_last        (out_ch.run_last)
);
